[rtl/core/pwmdm_pkg.sv]
// Shared types and constants for the PWM channel duty manager.
`default_nettype none

package pwmdm_pkg;

	localparam int CHAN_W   = 5;
	localparam int DUTY_W   = 16;
	localparam int PERIOD_W = 16;
	localparam int CMD_W    = 3;
	localparam int DIR_W    = 2;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd3000;

	typedef enum logic [CMD_W-1:0] {
		CMD_INIT   = 3'd0,
		CMD_DEINIT = 3'd1,
		CMD_ON     = 3'd2,
		CMD_ON_SET = 3'd3,
		CMD_OFF    = 3'd4,
		CMD_SET    = 3'd5,
		CMD_STEP   = 3'd6,
		CMD_READ   = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_NOT_INIT = 2'd2,
		ST_NOT_ON   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ACT_NONE    = 2'd0,
		ACT_CONFIG  = 2'd1,
		ACT_COMPARE = 2'd2,
		ACT_STOP    = 2'd3
	} action_t;

	typedef enum logic [DIR_W-1:0] {
		DIR_UP   = 2'd0,
		DIR_DOWN = 2'd1
	} dir_t;

	// Result fields that do not depend on the compare arithmetic
	typedef struct packed {
		status_t           status;
		action_t           action;
		logic [1:0]        timer_index;
		logic [2:0]        compare_slot;
		logic              inverse_mode;
		logic              on_status;
		logic [DUTY_W-1:0] stored_duty;
		logic              initialized;
	} res_t;

endpackage

`default_nettype wire

[rtl/core/pwm_channel_duty_manager_unit.sv]
// Top level of the PWM channel duty manager: channel table and compare pipeline.
`default_nettype none

// One command request is taken per clock cycle while the output is not stalled, and
// its result leaves through the output register. The channel table is read,
// updated and written in the cycle after the input register, so consecutive
// requests to the same channel see each other's effects. The compare value
// period_ticks * duty / MAX_DUTY is formed over four further stages: a 16x16
// product, a reciprocal multiply, a back-multiply and a single correction step.
// Each stage advances when the next one is empty or moving, so bubbles close up
// and the input keeps accepting while a finished result waits at the output,
// until all six registers hold a request.
// The period register may be written only while no request is in flight.
module pwm_channel_duty_manager_unit
	import pwmdm_pkg::*;
#(
	parameter int CHANNELS = 16,
	parameter int MAX_DUTY = 1000,
	parameter int MIN_DUTY = 0
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration: period_ticks
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data,
	// command requests
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [4:0] channel, [20:5] duty_value, [21] inverse_request, [23:22] step_direction
	input  wire logic [23:0] s_axis_tdata,
	// [2:0] command
	input  wire logic [2:0]  s_axis_tuser,
	// results
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [1:0] status, [3:2] action, [5:4] timer_index, [8:6] compare_slot,
	// [24:9] compare_value, [25] inverse_mode, [26] on_status,
	// [42:27] stored duty, [43] initialized, [47:44] zero
	output logic [47:0]      m_axis_tdata
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [DUTY_W-1:0] MAX_D = DUTY_W'(MAX_DUTY);
	localparam logic [DUTY_W-1:0] MIN_D = DUTY_W'(MIN_DUTY);
	localparam logic [CHAN_W:0]   CH_LIMIT = (CHAN_W+1)'(CHANNELS);
	// floor(2^32 / MAX_DUTY), held to 32 bits; leaves the quotient at most one low
	localparam logic [63:0] RECIP_FULL = 64'h1_0000_0000 / MAX_DUTY;
	localparam logic [31:0] RECIP = (RECIP_FULL > 64'h0000_0000_FFFF_FFFF) ?
		32'hFFFF_FFFF : RECIP_FULL[31:0];

	// period register
	logic [PERIOD_W-1:0] period_q;

	// channel table
	logic              init_q [CHANNELS];
	logic              on_q   [CHANNELS];
	logic              inv_q  [CHANNELS];
	logic [DUTY_W-1:0] duty_q [CHANNELS];

	// stage 1: input register
	logic              vld_s1;
	cmd_t              cmd_s1;
	logic [CHAN_W-1:0] chan_s1;
	logic [DUTY_W-1:0] dval_s1;
	logic              invr_s1;
	logic [DIR_W-1:0]  dir_s1;

	// stage 2: table result and selected duty
	logic              vld_s2;
	res_t              res_s2;
	logic [DUTY_W-1:0] dsel_s2;

	// stage 3: period * duty
	logic              vld_s3;
	res_t              res_s3;
	logic [31:0]       num_s3;

	// stage 4: estimated quotient
	logic              vld_s4;
	res_t              res_s4;
	logic [31:0]       num_s4;
	logic [15:0]       qest_s4;

	// stage 5: back-multiplied estimate
	logic              vld_s5;
	res_t              res_s5;
	logic [31:0]       num_s5;
	logic [15:0]       qest_s5;
	logic [31:0]       qmul_s5;

	// output register
	logic              out_vld_q;
	res_t              res_q;
	logic [15:0]       cmp_q;

	// stage enables
	logic en_out, en5, en4, en3, en2, en1;

	assign en_out = !out_vld_q || m_axis_tready;
	assign en5    = !vld_s5 || en_out;
	assign en4    = !vld_s4 || en5;
	assign en3    = !vld_s3 || en4;
	assign en2    = !vld_s2 || en3;
	assign en1    = !vld_s1 || en2;

	assign s_axis_tready = en1;

	// table lookup and next channel state
	logic              ch_ok;
	logic [CH_W-1:0]   idx;
	logic              cur_init, cur_on, cur_inv;
	logic [DUTY_W-1:0] cur_duty;
	logic              nxt_init, nxt_on, nxt_inv;
	logic [DUTY_W-1:0] nxt_duty;
	logic              tbl_wr;
	res_t              res_a;
	logic [DUTY_W-1:0] dsel_a;
	logic [DUTY_W:0]   up_sum;
	logic [DUTY_W:0]   down_lim;
	logic [DUTY_W-1:0] stepped_duty;

	assign ch_ok    = {1'b0, chan_s1} < CH_LIMIT;
	assign idx      = chan_s1[CH_W-1:0];
	assign cur_init = init_q[idx];
	assign cur_on   = on_q[idx];
	assign cur_inv  = inv_q[idx];
	assign cur_duty = duty_q[idx];

	// saturating step in both directions
	assign up_sum   = {1'b0, cur_duty} + {1'b0, dval_s1};
	assign down_lim = {1'b0, MIN_D} + {1'b0, dval_s1};

	always_comb begin
		if (dir_s1 == DIR_UP) begin
			stepped_duty = (up_sum > {1'b0, MAX_D}) ? MAX_D : up_sum[DUTY_W-1:0];
		end else begin
			stepped_duty = ({1'b0, cur_duty} < down_lim) ? MIN_D : (cur_duty - dval_s1);
		end
	end

	always_comb begin
		res_a    = '0;
		dsel_a   = '0;
		nxt_init = cur_init;
		nxt_on   = cur_on;
		nxt_inv  = cur_inv;
		nxt_duty = cur_duty;
		if (!ch_ok) begin
			res_a.status = ST_INVALID;
		end else begin
			case (cmd_s1)
				CMD_INIT: begin
					if (!cur_init) begin
						res_a.action = ACT_CONFIG;
						nxt_init     = 1'b1;
						nxt_on       = 1'b0;
						nxt_inv      = invr_s1;
						nxt_duty     = '0;
					end
				end
				CMD_DEINIT: begin
					if (cur_init) begin
						res_a.action = ACT_STOP;
						nxt_init     = 1'b0;
						nxt_on       = 1'b0;
						nxt_inv      = 1'b0;
						nxt_duty     = '0;
					end
				end
				CMD_ON: begin
					if (!cur_init) begin
						res_a.status = ST_NOT_INIT;
					end else begin
						res_a.action = ACT_COMPARE;
						dsel_a       = (cur_duty > MAX_D) ? MAX_D : cur_duty;
						nxt_on       = 1'b1;
					end
				end
				CMD_ON_SET: begin
					if (dval_s1 > MAX_D) begin
						res_a.status = ST_INVALID;
					end else if (!cur_init) begin
						res_a.status = ST_NOT_INIT;
					end else begin
						res_a.action = ACT_COMPARE;
						dsel_a       = dval_s1;
						nxt_duty     = dval_s1;
						nxt_on       = 1'b1;
					end
				end
				CMD_OFF: begin
					if (!cur_init) begin
						res_a.status = ST_NOT_INIT;
					end else begin
						res_a.action = ACT_COMPARE;
						nxt_on       = 1'b0;
					end
				end
				CMD_SET: begin
					if (dval_s1 > MAX_D) begin
						res_a.status = ST_INVALID;
					end else if (!cur_init) begin
						res_a.status = ST_NOT_INIT;
					end else if (!cur_on) begin
						res_a.status = ST_NOT_ON;
					end else begin
						res_a.action = ACT_COMPARE;
						dsel_a       = dval_s1;
						nxt_duty     = dval_s1;
					end
				end
				CMD_STEP: begin
					if (dir_s1 != DIR_UP && dir_s1 != DIR_DOWN) begin
						res_a.status = ST_INVALID;
					end else if (!cur_init) begin
						res_a.status = ST_NOT_INIT;
					end else if (!cur_on) begin
						res_a.status = ST_NOT_ON;
					end else begin
						res_a.action = ACT_COMPARE;
						nxt_duty     = stepped_duty;
						dsel_a       = (stepped_duty > MAX_D) ? MAX_D : stepped_duty;
					end
				end
				CMD_READ: begin
					if (!cur_init) begin
						res_a.status = ST_NOT_INIT;
					end
				end
				default: begin
					res_a.status = ST_OK;
				end
			endcase
			if (res_a.action != ACT_NONE) begin
				res_a.timer_index  = chan_s1[3:2];
				res_a.compare_slot = {1'b0, chan_s1[1:0]} + 3'd1;
			end
			res_a.inverse_mode = nxt_inv;
			res_a.on_status    = nxt_on;
			res_a.stored_duty  = nxt_duty;
			res_a.initialized  = nxt_init;
		end
	end

	assign tbl_wr = vld_s1 && en2 && ch_ok;

	// period register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (cfg_wr_en) begin
			period_q <= cfg_wr_data;
		end
	end

	// write back the channel table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				init_q[i] <= 1'b0;
				on_q[i]   <= 1'b0;
				inv_q[i]  <= 1'b0;
				duty_q[i] <= '0;
			end
		end else if (tbl_wr) begin
			init_q[idx] <= nxt_init;
			on_q[idx]   <= nxt_on;
			inv_q[idx]  <= nxt_inv;
			duty_q[idx] <= nxt_duty;
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (en1)    vld_s1    <= s_axis_tvalid;
			if (en2)    vld_s2    <= vld_s1;
			if (en3)    vld_s3    <= vld_s2;
			if (en4)    vld_s4    <= vld_s3;
			if (en5)    vld_s5    <= vld_s4;
			if (en_out) out_vld_q <= vld_s5;
		end
	end

	// capture the request
	always_ff @(posedge clk) begin
		if (en1) begin
			cmd_s1  <= cmd_t'(s_axis_tuser);
			chan_s1 <= s_axis_tdata[4:0];
			dval_s1 <= s_axis_tdata[20:5];
			invr_s1 <= s_axis_tdata[21];
			dir_s1  <= s_axis_tdata[23:22];
		end
	end

	// advance the compare pipeline
	always_ff @(posedge clk) begin
		if (en2) begin
			res_s2  <= res_a;
			dsel_s2 <= dsel_a;
		end
		if (en3) begin
			res_s3 <= res_s2;
			num_s3 <= 32'(period_q) * 32'(dsel_s2);
		end
		if (en4) begin
			res_s4  <= res_s3;
			num_s4  <= num_s3;
			qest_s4 <= 16'((64'(num_s3) * 64'(RECIP)) >> 32);
		end
		if (en5) begin
			res_s5  <= res_s4;
			num_s5  <= num_s4;
			qest_s5 <= qest_s4;
			qmul_s5 <= 32'(qest_s4) * 32'(MAX_D);
		end
	end

	// correct the estimate by one where the remainder reaches the divisor
	logic [31:0] rem_s5;
	logic [16:0] qfix_s5;

	assign rem_s5  = num_s5 - qmul_s5;
	assign qfix_s5 = {1'b0, qest_s5} + 17'((rem_s5 >= 32'(MAX_D)) ? 1 : 0);

	// hold the result until taken
	always_ff @(posedge clk) begin
		if (en_out) begin
			res_q <= res_s5;
			cmp_q <= qfix_s5[15:0];
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {
		4'b0000,
		res_q.initialized,
		res_q.stored_duty,
		res_q.on_status,
		res_q.inverse_mode,
		cmp_q,
		res_q.compare_slot,
		res_q.timer_index,
		res_q.action,
		res_q.status
	};

endmodule

`default_nettype wire
